// ===== rtl/core/literal_string_unescaper_assert.svh =====
// Assertion helpers for the string unescaper.
`ifndef LITERAL_STRING_UNESCAPER_ASSERT_SVH
`define LITERAL_STRING_UNESCAPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsu check failed");

// Next-cycle implication, checked outside reset.
`define LSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsu check failed");

`endif

// ===== rtl/core/lsu_pkg.sv =====
`timescale 1ns / 1ps
package lsu_pkg;

    localparam int NEST_LIMIT = 255;
    localparam logic [7:0] NEST_CAP = (NEST_LIMIT > 255) ? 8'd255 : 8'(NEST_LIMIT);

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [7:0] CC_LF  = 8'h0a;
    localparam logic [7:0] CC_CR  = 8'h0d;
    localparam logic [7:0] CC_TAB = 8'h09;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_FF  = 8'h0c;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_OCT  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       begins_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic       active;
        logic [7:0] nesting;
        t_mode      mode;
        logic [8:0] octal_value;
        logic [1:0] octal_digits;
    } t_state;

    // Up to two words per input byte; slot0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        t_out_word  slot0;
        t_out_word  slot1;
    } t_dec_res;

endpackage

// ===== rtl/core/lsu_decode.sv =====
`timescale 1ns / 1ps
module lsu_decode
    import lsu_pkg::*;
(
    input  t_state   i_state,
    input  t_in_word i_item,
    output t_state   o_state,
    output t_dec_res o_res
);

    t_state     st;
    t_state     nx;
    t_dec_res   res;
    logic [7:0] c;
    logic       c_oct;
    t_out_word  txt_word;
    logic       txt_esc;
    logic [7:0] txt_nest;
    logic       txt_active;
    logic [8:0] ov_n;
    logic [1:0] dg_n;
    logic [7:0] esc_byte;

    always_comb begin
        c     = i_item.in_byte;
        c_oct = c inside {[CH_ZERO:CH_SEVEN]};

        st = i_state;
        if (i_item.begins_string) begin
            st.active       = 1'b1;
            st.nesting      = 8'd0;
            st.mode         = MODE_TEXT;
            st.octal_value  = 9'd0;
            st.octal_digits = 2'd0;
        end

        // plain-text handling of c
        txt_word   = '{out_byte: c, byte_valid: 1'b1, string_done: 1'b0, last: 1'b0};
        txt_esc    = 1'b0;
        txt_nest   = st.nesting;
        txt_active = 1'b1;
        if (c == CH_BSLASH) begin
            txt_esc = 1'b1;
        end else if (c == CH_LPAREN) begin
            if (st.nesting < NEST_CAP) begin
                txt_nest = st.nesting + 8'd1;
            end
        end else if (c == CH_RPAREN) begin
            if (st.nesting == 8'd0) begin
                txt_active = 1'b0;
                txt_word   = '{out_byte: 8'd0, byte_valid: 1'b0, string_done: 1'b1,
                               last: 1'b0};
            end else begin
                txt_nest = st.nesting - 8'd1;
            end
        end

        case (c)
            CH_N:    esc_byte = CC_LF;
            CH_R:    esc_byte = CC_CR;
            CH_T:    esc_byte = CC_TAB;
            CH_B:    esc_byte = CC_BS;
            CH_F:    esc_byte = CC_FF;
            default: esc_byte = c;
        endcase

        ov_n = {st.octal_value[5:0], c[2:0]};
        dg_n = st.octal_digits + 2'd1;

        nx  = st;
        res = '0;
        if (st.active) begin
            case (st.mode)
                MODE_OCT: begin
                    if (c_oct) begin
                        if (dg_n == OCT_MAX_DIGITS) begin
                            res.count       = 2'd1;
                            res.slot0       = '{out_byte: ov_n[7:0], byte_valid: 1'b1,
                                                string_done: 1'b0, last: 1'b0};
                            nx.mode         = MODE_TEXT;
                            nx.octal_value  = 9'd0;
                            nx.octal_digits = 2'd0;
                        end else begin
                            nx.octal_value  = ov_n;
                            nx.octal_digits = dg_n;
                        end
                    end else begin
                        // flush the pending value, then treat c as text
                        res.slot0       = '{out_byte: st.octal_value[7:0], byte_valid: 1'b1,
                                            string_done: 1'b0, last: 1'b0};
                        nx.octal_value  = 9'd0;
                        nx.octal_digits = 2'd0;
                        if (txt_esc) begin
                            nx.mode   = MODE_ESC;
                            res.count = 2'd1;
                        end else begin
                            nx.mode    = MODE_TEXT;
                            res.slot1  = txt_word;
                            res.count  = 2'd2;
                            nx.nesting = txt_nest;
                            nx.active  = txt_active;
                        end
                    end
                end
                MODE_ESC: begin
                    if (c_oct) begin
                        nx.mode         = MODE_OCT;
                        nx.octal_value  = {6'd0, c[2:0]};
                        nx.octal_digits = 2'd1;
                    end else begin
                        nx.mode   = MODE_TEXT;
                        res.count = 2'd1;
                        res.slot0 = '{out_byte: esc_byte, byte_valid: 1'b1,
                                      string_done: 1'b0, last: 1'b0};
                    end
                end
                default: begin
                    if (txt_esc) begin
                        nx.mode = MODE_ESC;
                    end else begin
                        res.count  = 2'd1;
                        res.slot0  = txt_word;
                        nx.nesting = txt_nest;
                        nx.active  = txt_active;
                    end
                end
            endcase
        end

        if (res.count == 2'd1) begin
            res.slot0.last = 1'b1;
        end
        if (res.count == 2'd2) begin
            res.slot1.last = 1'b1;
        end

        o_state = nx;
        o_res   = res;
    end

endmodule

// ===== rtl/core/literal_string_unescaper.sv =====
`timescale 1ns / 1ps
// PDF literal string body decoder.
// Input channel (i_in_valid / o_in_stall / i_in_word): one raw body byte per
// word; set begins_string on the first byte after the opening parenthesis.
// Output channel (o_out_valid / i_out_stall / o_out_word): decoded words in
// order; last marks the final word caused by an input byte. A closing
// parenthesis at depth zero gives a word with string_done set and no byte.
// A taken byte is registered in the input register, then decoded into a
// 4-word output queue, and reaches o_out_word from the head of that queue.
// Throughput: one byte per cycle while the queue has room. The queue takes
// a byte's words only while it holds at most two, so sustained output of two
// words per byte (octal flush followed by text) runs at the one-word-per-cycle drain rate.
// Reset (synchronous, i_rst_n low) closes any open string and empties the
// input register and the queue. While the receiver stalls, the head word
// holds; the queue fills and o_in_stall then backs up the input side.
`include "literal_string_unescaper_assert.svh"
module literal_string_unescaper
    import lsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_in_vld;
    t_in_word  r_in;
    t_state    r_state;
    t_state    n_state;
    t_dec_res  dec_res;
    t_out_word r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_cnt;
    logic       room;
    logic       consume;
    logic       accept;
    logic       pop;
    logic [2:0] push_n;

    assign room    = (r_cnt <= 3'd2);
    assign consume = r_in_vld & room;
    assign accept  = i_in_valid & ~o_in_stall;
    assign pop     = o_out_valid & ~i_out_stall;
    assign push_n  = consume ? {1'b0, dec_res.count} : 3'd0;

    assign o_in_stall  = r_in_vld & ~room;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_word  = r_mem[r_rd_ptr];

    lsu_decode u_decode (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= (r_in_vld & ~consume) | accept;
        end
        if (accept) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{active: 1'b0, nesting: 8'd0, mode: MODE_TEXT,
                         octal_value: 9'd0, octal_digits: 2'd0};
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_cnt    <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[1:0];
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_cnt    <= r_cnt + push_n - {2'd0, pop};
        end
        if (push_n != 3'd0) begin
            r_mem[r_wr_ptr] <= dec_res.slot0;
        end
        if (push_n == 3'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= dec_res.slot1;
        end
    end

    `LSU_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4)
    `LSU_ASSERT_IMPL(a_done_no_byte, i_clk, i_rst_n, o_out_valid && o_out_word.string_done, !o_out_word.byte_valid && o_out_word.last)
    `LSU_ASSERT_IMPL(a_cnt_track, i_clk, i_rst_n, $past(i_rst_n), r_cnt == $past(r_cnt + push_n - {2'd0, pop}))
    `LSU_ASSERT_IMPL(a_nest_cap, i_clk, i_rst_n, 1'b1, r_state.nesting <= NEST_CAP)

endmodule
